// ===== sv/hps_pkg.sv =====
`timescale 1ns / 1ps

package hps_pkg;

   // request kinds carried in req_type
   typedef enum logic [1:0] {
      REQ_TICK  = 2'd0,
      REQ_START = 2'd1,
      REQ_STOP  = 2'd2
   } req_kind_type;

   // which frequency register drives the speaker
   typedef enum logic [1:0] {
      SEL_OFF  = 2'd0,
      SEL_MAIN = 2'd1,
      SEL_LOW  = 2'd2
   } tone_sel_type;

   // configuration register indexes
   localparam logic CSR_MAIN_TONE = 1'b0;
   localparam logic CSR_LOW_TONE  = 1'b1;

   localparam logic [15:0] MAIN_TONE_RESET = 16'd1000;
   localparam logic [15:0] LOW_TONE_RESET  = 16'd500;

   // pattern codes
   localparam logic [3:0] PAT_TONE_1S   = 4'd0;
   localparam logic [3:0] PAT_TONE_2S   = 4'd1;
   localparam logic [3:0] PAT_TONE_3S   = 4'd2;
   localparam logic [3:0] PAT_BEEP_2    = 4'd3;
   localparam logic [3:0] PAT_BEEP_3    = 4'd4;
   localparam logic [3:0] PAT_BEEP_4    = 4'd5;
   localparam logic [3:0] PAT_BEEP_TONE = 4'd6;
   localparam logic [3:0] PAT_BURST     = 4'd7;
   localparam logic [3:0] PAT_ALARM     = 4'd8;

   // step durations in millisecond ticks
   localparam logic [11:0] T_HALF  = 12'd500;
   localparam logic [11:0] T_ONE   = 12'd1000;
   localparam logic [11:0] T_TWO   = 12'd2000;
   localparam logic [11:0] T_THREE = 12'd3000;

   localparam logic [2:0] BURSTS = 3'd6;

   typedef struct packed {
      logic        sound_on;
      logic [15:0] tone_hz;
      logic        busy_res;
   } result_type;

endpackage

// ===== sv/hps_step.sv =====
`timescale 1ns / 1ps

module hps_step (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  hps_pkg::req_kind_type req_kind,
   input  logic [3:0]           horn_mode,
   input  logic [15:0]          main_tone_hz,
   input  logic [15:0]          low_tone_hz,
   output hps_pkg::result_type  result
);
   import hps_pkg::*;

   logic         active_ff, active_in;
   logic [3:0]   pattern_ff, pattern_in;
   logic [2:0]   step_ff, step_in;
   logic [2:0]   repeat_ff, repeat_in;
   logic [11:0]  wait_ff, wait_in;
   tone_sel_type tone_ff, tone_in;

   logic [11:0]  wait_dec;
   logic [2:0]   last_step;
   logic [2:0]   repeat_inc;
   logic [15:0]  hz;

   always_comb begin
      active_in  = active_ff;
      pattern_in = pattern_ff;
      step_in    = step_ff;
      repeat_in  = repeat_ff;
      wait_in    = wait_ff;
      tone_in    = tone_ff;
      wait_dec   = (wait_ff != 12'd0) ? wait_ff - 12'd1 : 12'd0;
      repeat_inc = repeat_ff + 3'd1;

      case (pattern_ff)
         PAT_BEEP_2: last_step = 3'd3;
         PAT_BEEP_3: last_step = 3'd5;
         default:    last_step = 3'd7;
      endcase

      if (accept) begin
         case (req_kind)
            REQ_START: begin
               active_in  = 1'b1;
               pattern_in = horn_mode;
               step_in    = 3'd0;
               repeat_in  = 3'd0;
               wait_in    = 12'd0;
            end
            REQ_STOP: begin
               active_in = 1'b0;
               tone_in   = SEL_OFF;
            end
            REQ_TICK: begin
               if (active_ff) begin
                  wait_in = wait_dec;
                  if (wait_dec == 12'd0) begin
                     case (pattern_ff)
                        PAT_TONE_1S, PAT_TONE_2S, PAT_TONE_3S: begin
                           if (step_ff == 3'd0) begin
                              tone_in = SEL_MAIN;
                              step_in = 3'd1;
                              case (pattern_ff)
                                 PAT_TONE_1S: wait_in = T_ONE;
                                 PAT_TONE_2S: wait_in = T_TWO;
                                 default:     wait_in = T_THREE;
                              endcase
                           end else if (step_ff == 3'd1) begin
                              tone_in   = SEL_OFF;
                              active_in = 1'b0;
                           end else begin
                              active_in = 1'b0;
                           end
                        end
                        PAT_BEEP_2, PAT_BEEP_3, PAT_BEEP_4: begin
                           if (step_ff > last_step) begin
                              active_in = 1'b0;
                           end else if (!step_ff[0]) begin
                              tone_in = SEL_MAIN;
                              wait_in = T_ONE;
                              step_in = step_ff + 3'd1;
                           end else if (step_ff == last_step) begin
                              tone_in   = SEL_OFF;
                              active_in = 1'b0;
                           end else begin
                              tone_in = SEL_OFF;
                              wait_in = T_ONE;
                              step_in = step_ff + 3'd1;
                           end
                        end
                        PAT_BEEP_TONE: begin
                           case (step_ff)
                              3'd0: begin
                                 tone_in = SEL_MAIN;
                                 wait_in = T_ONE;
                                 step_in = 3'd1;
                              end
                              3'd1: begin
                                 tone_in = SEL_OFF;
                                 wait_in = T_ONE;
                                 step_in = 3'd2;
                              end
                              3'd2: begin
                                 tone_in = SEL_MAIN;
                                 wait_in = T_THREE;
                                 step_in = 3'd3;
                              end
                              3'd3: begin
                                 tone_in   = SEL_OFF;
                                 active_in = 1'b0;
                              end
                              default: active_in = 1'b0;
                           endcase
                        end
                        PAT_BURST: begin
                           if (step_ff == 3'd0) begin
                              tone_in = SEL_MAIN;
                              wait_in = T_HALF;
                              step_in = 3'd1;
                           end else if (step_ff == 3'd1) begin
                              tone_in   = SEL_OFF;
                              wait_in   = T_HALF;
                              step_in   = 3'd0;
                              repeat_in = repeat_inc;
                              if (repeat_inc >= BURSTS) active_in = 1'b0;
                           end else begin
                              active_in = 1'b0;
                           end
                        end
                        PAT_ALARM: begin
                           if (step_ff == 3'd0) begin
                              tone_in = SEL_LOW;
                              wait_in = T_ONE;
                              step_in = 3'd1;
                           end else if (step_ff == 3'd1) begin
                              repeat_in = repeat_inc;
                              tone_in   = SEL_MAIN;
                              wait_in   = T_ONE;
                              step_in   = (repeat_inc >= BURSTS) ? 3'd2 : 3'd0;
                           end else if (step_ff == 3'd2) begin
                              tone_in   = SEL_OFF;
                              active_in = 1'b0;
                           end else begin
                              active_in = 1'b0;
                           end
                        end
                        default: active_in = 1'b0;
                     endcase
                  end
               end
            end
            default: ;
         endcase
      end

      case (tone_in)
         SEL_MAIN: hz = main_tone_hz;
         SEL_LOW:  hz = low_tone_hz;
         default:  hz = 16'd0;
      endcase

      result.sound_on = (hz != 16'd0);
      result.tone_hz  = hz;
      result.busy_res = active_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         pattern_ff <= 4'd0;
         step_ff    <= 3'd0;
         repeat_ff  <= 3'd0;
         wait_ff    <= 12'd0;
         tone_ff    <= SEL_OFF;
      end else begin
         active_ff  <= active_in;
         pattern_ff <= pattern_in;
         step_ff    <= step_in;
         repeat_ff  <= repeat_in;
         wait_ff    <= wait_in;
         tone_ff    <= tone_in;
      end
   end

   a_stop_silences: assert property (@(posedge clock) disable iff (reset)
      accept && req_kind == REQ_STOP |=> !active_ff && tone_ff == SEL_OFF)
      else $error("stop did not silence and idle");

   a_start_arms: assert property (@(posedge clock) disable iff (reset)
      accept && req_kind == REQ_START
      |=> active_ff && step_ff == 3'd0 && wait_ff == 12'd0 && repeat_ff == 3'd0)
      else $error("start did not arm the sequence");

   a_wait_bound: assert property (@(posedge clock) disable iff (reset)
      wait_ff <= T_THREE)
      else $error("step duration out of range");

   a_idle_tick_holds: assert property (@(posedge clock) disable iff (reset)
      accept && req_kind == REQ_TICK && !active_ff
      |=> !active_ff && $stable(tone_ff) && $stable(wait_ff))
      else $error("tick changed an idle sequencer");

endmodule

// ===== sv/hps_out_buf.sv =====
`timescale 1ns / 1ps

module hps_out_buf (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  hps_pkg::result_type push_data,
   output logic                full,
   output logic                out_valid,
   input  logic                out_stall,
   output hps_pkg::result_type out_data
);
   import hps_pkg::*;

   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_data_ff, out_data_in;
   result_type skid_data_ff, skid_data_in;
   logic       pop;

   assign pop = out_valid_ff && !out_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_data_in  = push_data;
            out_valid_in = push;
         end
      end else if (push) begin
         skid_data_in  = push_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held with empty output stage");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !push)
      else $error("transaction pushed into a full buffer");

   a_skid_moves_up: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && pop |=> out_valid_ff && !skid_valid_ff)
      else $error("skid entry lost on pop");

endmodule

// ===== sv/horn_pattern_sequencer.sv =====
`timescale 1ns / 1ps

// Horn pattern sequencer: drives a buzzer through one of nine timed patterns
// (plain tones, beep trains, beep then tone, bursts and a two-tone alarm).
// Each request transaction is a millisecond tick, a start with a pattern
// code, or a stop, and each one yields exactly one response transaction with
// the speaker and busy state after it is handled. One request is taken every
// clock cycle while req_stall is low; its response is registered. The whole
// step update (tick countdown plus step decode) is combinational, and a
// two-entry response buffer keeps requests flowing while a response waits
// downstream, so req_stall rises only when both entries hold untaken
// responses. Tone frequencies come from two registers on the csr_ port,
// written by the user only while the block is quiet; the block itself does not enforce this.

module horn_pattern_sequencer (
   input  logic        clock,
   input  logic        reset,

   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [3:0]  req_horn_mode,

   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_sound_on,
   output logic [15:0] rsp_tone_hz,
   output logic        rsp_busy_res,

   // register write port
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);
   import hps_pkg::*;

   logic [15:0] main_tone_ff, main_tone_in;
   logic [15:0] low_tone_ff, low_tone_in;

   logic       req_accept;
   logic       buf_full;
   result_type step_result;
   result_type rsp_data;

   // register writes are always taken
   assign csr_ready = 1'b1;

   always_comb begin
      main_tone_in = main_tone_ff;
      low_tone_in  = low_tone_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MAIN_TONE: main_tone_in = csr_data;
            CSR_LOW_TONE:  low_tone_in  = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_tone_ff <= MAIN_TONE_RESET;
         low_tone_ff  <= LOW_TONE_RESET;
      end else begin
         main_tone_ff <= main_tone_in;
         low_tone_ff  <= low_tone_in;
      end
   end

   // a request transaction lands whenever the response buffer has room
   assign req_stall  = buf_full;
   assign req_accept = req_valid && !req_stall;

   // sequencer state and combinational step update
   hps_step u_step (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .req_kind     (req_kind_type'(req_type)),
      .horn_mode    (req_horn_mode),
      .main_tone_hz (main_tone_ff),
      .low_tone_hz  (low_tone_ff),
      .result       (step_result)
   );

   // response register plus skid entry
   hps_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_data (step_result),
      .full      (buf_full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

   assign rsp_sound_on = rsp_data.sound_on;
   assign rsp_tone_hz  = rsp_data.tone_hz;
   assign rsp_busy_res = rsp_data.busy_res;

endmodule
